FILE: src/touch_drag_to_wheel_scroll_core_assert.svh
// Assertion macros used by the checker of the touch scroll core.
`ifndef TOUCH_DRAG_TO_WHEEL_SCROLL_CORE_ASSERT_SVH
`define TOUCH_DRAG_TO_WHEEL_SCROLL_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_SAME_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tdws_pkg.sv
// Shared types, constants and a width helper for the touch scroll core.
package tdws_pkg;

    localparam int VALUE_W    = 12;
    localparam int PITCH_W    = 12;
    localparam int CARRY_W    = PITCH_W + 1;
    localparam int COUNT_W    = 17;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_SUBUNITS   = 16;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd16;

    localparam int COUNT_MAX     = 65535;
    localparam int COUNT_MIN_MAG = 65536;

    typedef enum logic [1:0] {
        EV_TOUCH = 2'd0,
        EV_ABS_X = 2'd1,
        EV_ABS_Y = 2'd2,
        EV_OTHER = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        OUT_SWALLOW = 2'd0,
        OUT_HWHEEL  = 2'd1,
        OUT_VWHEEL  = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        REG_X_PITCH = 2'd0,
        REG_Y_PITCH = 2'd1,
        REG_NATURAL = 2'd2,
        REG_SMOOTH  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic load_div;
        logic div_step;
        logic finish;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } status_t;

    // Width of the signed accumulator: scaled delta plus carry, with one guard bit.
    function automatic int acc_width(input int coord_bits, input int subunits);
        int scale_w;
        scale_w = coord_bits + 1 + $clog2(subunits + 1);
        return ((scale_w > CARRY_W) ? scale_w : CARRY_W) + 1;
    endfunction

endpackage

FILE: src/touch_drag_to_wheel_scroll_core.sv
// Touch scroll core: a coordinate after the baseline goes through the decode, load, divide
// and finish states of the one-bit-per-cycle restoring divider before the push into the
// output register; press, lift, baseline and other events go from decode straight to push.
// A new item is accepted the cycle after the previous result enters the output register;
// a finished result waits to enter it while the previous beat is still unaccepted.
// Reset (rst_n, asynchronous, active low) releases the finger, clears both baseline flags
// and both carries, and restores pitch 16, natural off and smooth off.
module touch_drag_to_wheel_scroll_core #(
    parameter int COORD_BITS = tdws_pkg::DEF_COORD_BITS,
    parameter int SUBUNITS   = tdws_pkg::DEF_SUBUNITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tdws_pkg::S_DATA_W-1:0]       s_tdata,   // [11:0] event_value
    input  logic [tdws_pkg::KIND_W-1:0]         s_tuser,   // [1:0] event_kind
    input  logic                                s_tlast,   // sync_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tdws_pkg::M_DATA_W-1:0]       m_tdata,   // [16:0] wheel_count
    output logic [tdws_pkg::KIND_W-1:0]         m_tuser,   // [1:0] out_kind
    output logic                                m_tlast,   // sync_out
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdws_pkg::ADDR_W-1:0]         paddr,
    input  logic [tdws_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tdws_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PITCH_W = tdws_pkg::PITCH_W;
    localparam int COUNT_W = tdws_pkg::COUNT_W;
    localparam int DATA_W  = tdws_pkg::APB_DATA_W;
    localparam int ITERS   = tdws_pkg::acc_width(COORD_BITS, SUBUNITS);

    logic [PITCH_W-1:0] x_pitch_reg, x_pitch_next;
    logic [PITCH_W-1:0] y_pitch_reg, y_pitch_next;
    logic               natural_reg, natural_next;
    logic               smooth_reg, smooth_next;
    logic               cfg_wr;
    tdws_pkg::reg_index_t reg_idx;

    tdws_pkg::cmd_t    cmd;
    tdws_pkg::status_t status;
    logic signed [COUNT_W-1:0] wheel_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = tdws_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        x_pitch_next = x_pitch_reg;
        y_pitch_next = y_pitch_reg;
        natural_next = natural_reg;
        smooth_next  = smooth_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                tdws_pkg::REG_X_PITCH: x_pitch_next = pwdata[PITCH_W-1:0];
                tdws_pkg::REG_Y_PITCH: y_pitch_next = pwdata[PITCH_W-1:0];
                tdws_pkg::REG_NATURAL: natural_next = pwdata[0];
                tdws_pkg::REG_SMOOTH:  smooth_next  = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tdws_pkg::REG_X_PITCH: prdata = DATA_W'(x_pitch_reg);
            tdws_pkg::REG_Y_PITCH: prdata = DATA_W'(y_pitch_reg);
            tdws_pkg::REG_NATURAL: prdata = DATA_W'(natural_reg);
            tdws_pkg::REG_SMOOTH:  prdata = DATA_W'(smooth_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pitch_reg <= tdws_pkg::PITCH_RESET;
            y_pitch_reg <= tdws_pkg::PITCH_RESET;
            natural_reg <= 1'b0;
            smooth_reg  <= 1'b0;
        end
        else
        begin
            x_pitch_reg <= x_pitch_next;
            y_pitch_reg <= y_pitch_next;
            natural_reg <= natural_next;
            smooth_reg  <= smooth_next;
        end
    end

    tdws_ctrl #(
        .ITERS (ITERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdws_dp #(
        .COORD_BITS (COORD_BITS),
        .SUBUNITS   (SUBUNITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .event_kind   (s_tuser),
        .event_value  (s_tdata[tdws_pkg::VALUE_W-1:0]),
        .sync_in      (s_tlast),
        .x_pitch      (x_pitch_reg),
        .y_pitch      (y_pitch_reg),
        .natural_mode (natural_reg),
        .smooth_mode  (smooth_reg),
        .out_kind     (m_tuser),
        .wheel_count  (wheel_count),
        .sync_out     (m_tlast)
    );

    assign m_tdata = {{(tdws_pkg::M_DATA_W - COUNT_W){1'b0}}, wheel_count};

endmodule

FILE: src/tdws_ctrl.sv
// Sequencer for the touch scroll core: handshakes and divider iteration count.
module tdws_ctrl #(
    parameter int ITERS = tdws_pkg::acc_width(tdws_pkg::DEF_COORD_BITS, tdws_pkg::DEF_SUBUNITS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tdws_pkg::status_t status,
    output tdws_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(ITERS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_PUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = status.need_div ? ST_LOAD : ST_PUSH;
            end
            ST_LOAD:
            begin
                cmd.load_div = 1'b1;
                cnt_next     = CNT_W'(ITERS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // The output register is free when empty or being drained this cycle.
                if (!m_valid_reg || m_tready)
                begin
                    cmd.push     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: src/tdws_dp.sv
// Datapath of the touch scroll core: touch state, accumulator, divider, result registers.
module tdws_dp #(
    parameter int COORD_BITS = tdws_pkg::DEF_COORD_BITS,
    parameter int SUBUNITS   = tdws_pkg::DEF_SUBUNITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tdws_pkg::cmd_t                        cmd,
    output tdws_pkg::status_t                     status,
    input  logic [tdws_pkg::KIND_W-1:0]           event_kind,
    input  logic [tdws_pkg::VALUE_W-1:0]          event_value,
    input  logic                                  sync_in,
    input  logic [tdws_pkg::PITCH_W-1:0]          x_pitch,
    input  logic [tdws_pkg::PITCH_W-1:0]          y_pitch,
    input  logic                                  natural_mode,
    input  logic                                  smooth_mode,
    output logic [tdws_pkg::KIND_W-1:0]           out_kind,
    output logic signed [tdws_pkg::COUNT_W-1:0]   wheel_count,
    output logic                                  sync_out
);

    localparam int PITCH_W = tdws_pkg::PITCH_W;
    localparam int CARRY_W = tdws_pkg::CARRY_W;
    localparam int COUNT_W = tdws_pkg::COUNT_W;
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ACC_W   = tdws_pkg::acc_width(COORD_BITS, SUBUNITS);
    localparam int EXT_W   = (ACC_W > COUNT_W + 1) ? ACC_W : COUNT_W + 1;

    localparam logic signed [ACC_W-1:0] SUB_S = ACC_W'(SUBUNITS);

    // Item registers.
    tdws_pkg::event_kind_t   kind_reg;
    logic [COORD_BITS-1:0]   coord_reg;
    logic                    press_reg;
    logic                    sync_reg;

    // Touch tracking state.
    logic                        finger_reg, finger_next;
    logic                        bxv_reg, bxv_next;
    logic                        byv_reg, byv_next;
    logic [COORD_BITS-1:0]       base_x_reg, base_y_reg;
    logic signed [CARRY_W-1:0]   carry_x_reg, carry_x_next;
    logic signed [CARRY_W-1:0]   carry_y_reg, carry_y_next;

    // Accumulator and restoring divider.
    logic signed [ACC_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [ACC_W-1:0]        quo_reg;
    logic [PITCH_W-1:0]      rem_reg;
    logic [PITCH_W-1:0]      dsr_reg;

    // Pending result and output register.
    tdws_pkg::out_kind_t     res_kind_reg, out_kind_reg;
    logic [COUNT_W-1:0]      res_count_reg, out_count_reg;
    logic                    res_sync_reg, out_sync_reg;

    logic                      is_x, is_y, need_div;
    logic [COORD_BITS-1:0]     base_sel;
    logic signed [CARRY_W-1:0] carry_sel;
    logic signed [DELTA_W-1:0] delta;
    logic signed [ACC_W-1:0]   delta_ext, scaled, acc_next;
    logic [ACC_W-1:0]          acc_mag;
    logic [PITCH_W-1:0]        pitch_sel, divisor;
    logic [PITCH_W:0]          rem_shift, rem_sub;
    logic                      fits;
    logic [PITCH_W-1:0]        rem_step;
    logic                      flip, q_nz;
    logic [EXT_W-1:0]          q_ext;
    logic [COUNT_W-1:0]        sat_mag, count_fin;
    logic signed [CARRY_W-1:0] rem_ext, carry_fin;

    assign is_x     = (kind_reg == tdws_pkg::EV_ABS_X);
    assign is_y     = (kind_reg == tdws_pkg::EV_ABS_Y);
    assign need_div = finger_reg && ((is_x && bxv_reg) || (is_y && byv_reg));
    assign status.need_div = need_div;

    assign base_sel  = is_x ? base_x_reg : base_y_reg;
    assign carry_sel = is_x ? carry_x_reg : carry_y_reg;
    assign delta     = $signed({1'b0, coord_reg}) - $signed({1'b0, base_sel});
    assign delta_ext = ACC_W'(delta);
    assign scaled    = smooth_mode ? delta_ext * SUB_S : delta_ext;
    assign acc_next  = scaled + ACC_W'(carry_sel);

    assign acc_mag   = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign pitch_sel = is_x ? x_pitch : y_pitch;
    assign divisor   = (pitch_sel == '0) ? PITCH_W'(1) : pitch_sel;

    // One quotient bit per step, dividend bits shifted in from the top.
    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign rem_step  = fits ? rem_sub[PITCH_W-1:0] : rem_shift[PITCH_W-1:0];

    // Quotient takes the dividend sign; the axis convention may flip it again.
    assign flip  = neg_reg ^ (is_x ? natural_mode : !natural_mode);
    assign q_nz  = |quo_reg;
    assign q_ext = EXT_W'(quo_reg);

    always_comb
    begin
        if (flip)
        begin
            sat_mag = (q_ext > EXT_W'(tdws_pkg::COUNT_MIN_MAG)) ?
                      COUNT_W'(tdws_pkg::COUNT_MIN_MAG) : q_ext[COUNT_W-1:0];
        end
        else
        begin
            sat_mag = (q_ext > EXT_W'(tdws_pkg::COUNT_MAX)) ?
                      COUNT_W'(tdws_pkg::COUNT_MAX) : q_ext[COUNT_W-1:0];
        end
    end

    assign count_fin = flip ? COUNT_W'(-sat_mag) : sat_mag;
    assign rem_ext   = {1'b0, rem_reg};
    assign carry_fin = neg_reg ? -rem_ext : rem_ext;

    always_comb
    begin
        finger_next  = finger_reg;
        bxv_next     = bxv_reg;
        byv_next     = byv_reg;
        carry_x_next = carry_x_reg;
        carry_y_next = carry_y_reg;
        if (cmd.decode && !need_div)
        begin
            unique case (kind_reg)
                tdws_pkg::EV_TOUCH:
                begin
                    // A fresh press starts a new drag from scratch.
                    if (press_reg && !finger_reg)
                    begin
                        bxv_next     = 1'b0;
                        byv_next     = 1'b0;
                        carry_x_next = '0;
                        carry_y_next = '0;
                    end
                    finger_next = press_reg;
                end
                tdws_pkg::EV_ABS_X:
                begin
                    if (finger_reg)
                    begin
                        bxv_next = 1'b1;
                    end
                end
                tdws_pkg::EV_ABS_Y:
                begin
                    if (finger_reg)
                    begin
                        byv_next = 1'b1;
                    end
                end
                tdws_pkg::EV_OTHER:
                begin
                end
            endcase
        end
        if (cmd.finish)
        begin
            if (is_x)
            begin
                carry_x_next = carry_fin;
            end
            else
            begin
                carry_y_next = carry_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_reg  <= 1'b0;
            bxv_reg     <= 1'b0;
            byv_reg     <= 1'b0;
            carry_x_reg <= '0;
            carry_y_reg <= '0;
        end
        else
        begin
            finger_reg  <= finger_next;
            bxv_reg     <= bxv_next;
            byv_reg     <= byv_next;
            carry_x_reg <= carry_x_next;
            carry_y_reg <= carry_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= tdws_pkg::event_kind_t'(event_kind);
            coord_reg <= COORD_BITS'(event_value);
            press_reg <= |event_value;
            sync_reg  <= sync_in;
        end
        if (cmd.decode)
        begin
            if (need_div)
            begin
                acc_reg <= acc_next;
            end
            else
            begin
                res_kind_reg  <= tdws_pkg::OUT_SWALLOW;
                res_count_reg <= '0;
                res_sync_reg  <= sync_reg;
                if (finger_reg && is_x)
                begin
                    base_x_reg <= coord_reg;
                end
                if (finger_reg && is_y)
                begin
                    base_y_reg <= coord_reg;
                end
            end
        end
        if (cmd.load_div)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            quo_reg <= acc_mag;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
            rem_reg <= rem_step;
        end
        if (cmd.finish)
        begin
            if (q_nz)
            begin
                res_kind_reg <= is_x ? tdws_pkg::OUT_HWHEEL : tdws_pkg::OUT_VWHEEL;
            end
            else
            begin
                res_kind_reg <= tdws_pkg::OUT_SWALLOW;
            end
            res_count_reg <= count_fin;
            res_sync_reg  <= sync_reg;
            if (is_x)
            begin
                base_x_reg <= coord_reg;
            end
            else
            begin
                base_y_reg <= coord_reg;
            end
        end
        if (cmd.push)
        begin
            out_kind_reg  <= res_kind_reg;
            out_count_reg <= res_count_reg;
            out_sync_reg  <= res_sync_reg;
        end
    end

    assign out_kind    = out_kind_reg;
    assign wheel_count = $signed(out_count_reg);
    assign sync_out    = out_sync_reg;

endmodule

FILE: src/tdws_checker.sv
// Port-level checker for the touch scroll core, bound to the top level.
`include "touch_drag_to_wheel_scroll_core_assert.svh"

module tdws_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tdws_pkg::M_DATA_W-1:0]     m_tdata,
    input logic [tdws_pkg::KIND_W-1:0]       m_tuser
);

    // A stalled result beat keeps its payload.
    `AST_NEXT_CYCLE(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output beat changed")

    // A swallowed beat carries a zero count.
    `AST_SAME_CYCLE(a_swallow_zero, m_tvalid && (m_tuser == tdws_pkg::OUT_SWALLOW), m_tdata[tdws_pkg::COUNT_W-1:0] == '0, "swallowed beat with nonzero count")

    // A wheel beat carries a nonzero count and a legal kind.
    `AST_SAME_CYCLE(a_wheel_nonzero, m_tvalid && (m_tuser != tdws_pkg::OUT_SWALLOW), (m_tdata[tdws_pkg::COUNT_W-1:0] != '0) && ((m_tuser == tdws_pkg::OUT_HWHEEL) || (m_tuser == tdws_pkg::OUT_VWHEEL)), "bad wheel beat")

    // Each accepted item is processed alone, so the input closes right after a beat.
    `AST_NEXT_CYCLE(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

endmodule

bind touch_drag_to_wheel_scroll_core tdws_checker u_checker (.*);

FILE: test/touch_drag_to_wheel_scroll_core_tb.sv
// Self-checking testbench for the touch drag to wheel scroll core.
`timescale 1ns / 100ps

module touch_drag_to_wheel_scroll_core_tb;
    import tdws_pkg::*;

    localparam int SUBUNITS     = DEF_SUBUNITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SCRIPT_LEN   = 20;
    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 85;
    localparam int SETTLE       = 30;

    typedef struct packed {
        out_kind_t   kind;
        logic [16:0] count;
        logic        sync;
    } wheel_beat_t;

    typedef struct packed {
        logic        valid;
        wheel_beat_t beat;
    } pin_t;

    typedef struct packed {
        int notches;
        int rem;
    } axis_step_t;

    typedef struct packed {
        event_kind_t kind;
        logic [11:0] value;
        logic        sync;
        logic        pinned;
        out_kind_t   exp_kind;
        logic [16:0] exp_count;
    } drag_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // [11:0] event_value
    logic [KIND_W-1:0]     s_tuser;   // [1:0] event_kind
    logic                  s_tlast;   // sync_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // [16:0] wheel_count
    logic [KIND_W-1:0]     m_tuser;   // [1:0] out_kind
    logic                  m_tlast;   // sync_out
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    touch_drag_to_wheel_scroll_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the block's registers and tracking state.
    logic [11:0] x_pitch    = 12'd16;
    logic [11:0] y_pitch    = 12'd16;
    logic        natural_on = 1'b0;
    logic        smooth_on  = 1'b0;
    logic        finger_down = 1'b0;
    logic [11:0] base_x = '0;
    logic [11:0] base_y = '0;
    logic        bx_valid = 1'b0;
    logic        by_valid = 1'b0;
    int          carry_x = 0;
    int          carry_y = 0;

    wheel_beat_t wheel_expect_q[$];
    pin_t        pinned_q[$];
    int          mismatch_count = 0;
    logic        no_idle = 1'b0;

    drag_row_t script [SCRIPT_LEN] = '{
        '{EV_OTHER, 12'hFFF, 1'b1, 1'b1, OUT_SWALLOW, 17'd0},   // other event
        '{EV_ABS_X, 12'd100, 1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // coordinate while up
        '{EV_TOUCH, 12'd0,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // lift while up
        '{EV_TOUCH, 12'hFFF, 1'b1, 1'b1, OUT_SWALLOW, 17'd0},   // press
        '{EV_ABS_X, 12'd0,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // X baseline
        '{EV_ABS_Y, 12'hFFF, 1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // Y baseline
        '{EV_ABS_X, 12'hFFF, 1'b1, 1'b1, OUT_HWHEEL,  17'd255},
        '{EV_ABS_X, 12'hFFF, 1'b0, 1'b0, OUT_SWALLOW, 17'd0},   // carry alone, zero count
        '{EV_ABS_Y, 12'd0,   1'b0, 1'b1, OUT_VWHEEL,  17'd255},
        '{EV_TOUCH, 12'd1,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // press while down
        '{EV_ABS_X, 12'd4079, 1'b0, 1'b0, OUT_SWALLOW, 17'd0},
        '{EV_ABS_X, 12'd4063, 1'b1, 1'b0, OUT_SWALLOW, 17'd0},
        '{EV_OTHER, 12'd0,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},
        '{EV_TOUCH, 12'd0,   1'b1, 1'b1, OUT_SWALLOW, 17'd0},   // lift
        '{EV_TOUCH, 12'd0,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // lift while up
        '{EV_ABS_Y, 12'd5,   1'b0, 1'b1, OUT_SWALLOW, 17'd0},
        '{EV_TOUCH, 12'h800, 1'b0, 1'b1, OUT_SWALLOW, 17'd0},   // new touch clears state
        '{EV_ABS_Y, 12'd1000, 1'b0, 1'b1, OUT_SWALLOW, 17'd0},
        '{EV_ABS_Y, 12'd1032, 1'b0, 1'b0, OUT_SWALLOW, 17'd0},
        '{EV_ABS_X, 12'd2047, 1'b1, 1'b1, OUT_SWALLOW, 17'd0}   // X baseline again
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic axis_step_t divide_axis(int delta, logic [11:0] pitch, int carry);
        axis_step_t st;
        int divisor;
        int acc;
        divisor = (pitch != 12'd0) ? int'(pitch) : 1;
        acc = smooth_on ? delta * SUBUNITS : delta;
        acc = acc + carry;
        st.notches = acc / divisor;
        st.rem = acc - st.notches * divisor;
        return st;
    endfunction

    function automatic logic [16:0] clip_count(int n);
        if (n > COUNT_MAX)
            return 17'(COUNT_MAX);
        if (n < -COUNT_MIN_MAG)
            return 17'(-COUNT_MIN_MAG);
        return 17'(n);
    endfunction

    // Advances the shadow state by one event and returns the wheel beat it causes.
    function automatic wheel_beat_t predict_scroll(event_kind_t kind, logic [11:0] value,
                                                   logic sync);
        wheel_beat_t beat;
        axis_step_t st;
        int notches;
        beat.kind = OUT_SWALLOW;
        beat.count = '0;
        beat.sync = sync;
        case (kind)
            EV_TOUCH:
            begin
                if (value != 12'd0 && !finger_down)
                begin
                    bx_valid = 1'b0;
                    by_valid = 1'b0;
                    carry_x = 0;
                    carry_y = 0;
                end
                finger_down = (value != 12'd0);
            end
            EV_ABS_X:
            begin
                if (finger_down && !bx_valid)
                begin
                    base_x = value;
                    bx_valid = 1'b1;
                end
                else if (finger_down)
                begin
                    st = divide_axis(int'(value) - int'(base_x), x_pitch, carry_x);
                    carry_x = st.rem;
                    base_x = value;
                    notches = natural_on ? -st.notches : st.notches;
                    if (notches != 0)
                    begin
                        beat.kind = OUT_HWHEEL;
                        beat.count = clip_count(notches);
                    end
                end
            end
            EV_ABS_Y:
            begin
                if (finger_down && !by_valid)
                begin
                    base_y = value;
                    by_valid = 1'b1;
                end
                else if (finger_down)
                begin
                    st = divide_axis(int'(value) - int'(base_y), y_pitch, carry_y);
                    carry_y = st.rem;
                    base_y = value;
                    notches = natural_on ? st.notches : -st.notches;
                    if (notches != 0)
                    begin
                        beat.kind = OUT_VWHEEL;
                        beat.count = clip_count(notches);
                    end
                end
            end
            default: ;
        endcase
        return beat;
    endfunction

    // Scoreboard: predicts on every accepted event and checks every accepted wheel beat.
    always @(posedge clk)
    begin
        wheel_beat_t want;
        wheel_beat_t guess;
        pin_t pin;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (wheel_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual kind %0d count %0d",
                             $time, m_tuser, $signed(m_tdata[16:0]));
                    mismatch_count++;
                end
                else
                begin
                    want = wheel_expect_q.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $display("%0t: out_kind expected %0d actual %0d",
                                 $time, want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[16:0] !== want.count)
                    begin
                        $display("%0t: wheel_count expected %0d actual %0d", $time,
                                 $signed(want.count), $signed(m_tdata[16:0]));
                        mismatch_count++;
                    end
                    if (m_tlast !== want.sync)
                    begin
                        $display("%0t: sync_out expected %0d actual %0d",
                                 $time, want.sync, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pin = pinned_q.pop_front();
                guess = predict_scroll(event_kind_t'(s_tuser), s_tdata[11:0], s_tlast);
                wheel_expect_q.push_back(pin.valid ? pin.beat : guess);
            end
        end
    end

    // Wheel side: random stall before each beat unless idling is switched off.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : int'($urandom_range(0, 17));
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_event(input event_kind_t kind, input logic [11:0] value,
                              input logic sync, input pin_t pin);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 17));
        pinned_q.push_back(pin);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, value};
        s_tuser  <= kind;
        s_tlast  <= sync;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_plain(input event_kind_t kind, input logic [11:0] value,
                              input logic sync);
        send_event(kind, value, sync, '0);
    endtask

    // Holds the event side until every expected wheel beat has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (wheel_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [11:0] value);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        if (idx == REG_X_PITCH || idx == REG_Y_PITCH)
            pwdata <= {junk[31:12], value};
        else
            pwdata <= {junk[31:1], value[0]};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_PITCH: x_pitch = value;
            REG_Y_PITCH: y_pitch = value;
            REG_NATURAL: natural_on = value[0];
            REG_SMOOTH:  smooth_on = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [11:0] xp, input logic [11:0] yp,
                             input logic nat, input logic smooth);
        repeat (4) @(posedge clk);
        write_reg(REG_X_PITCH, xp);
        write_reg(REG_Y_PITCH, yp);
        write_reg(REG_NATURAL, {11'b0, nat});
        write_reg(REG_SMOOTH, {11'b0, smooth});
    endtask

    // Finger walk: mostly small steps, some larger swings, now and then a jump.
    function automatic int walk_coord(int pos);
        int grade;
        int step;
        grade = int'($urandom_range(0, 9));
        if (grade == 9)
            return int'($urandom_range(0, 4095));
        if (grade < 6)
            step = int'($urandom_range(0, 96)) - 48;
        else
            step = int'($urandom_range(0, 1400)) - 700;
        pos = pos + step;
        if (pos < 0)
            pos = 0;
        if (pos > 4095)
            pos = 4095;
        return pos;
    endfunction

    initial
    begin
        int phase;
        int n;
        int roll;
        int pos_x;
        int pos_y;
        logic touching;
        logic sync;
        logic [11:0] value;
        event_kind_t kind;
        pin_t pin;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed events at the reset settings.
        for (n = 0; n < SCRIPT_LEN; n++)
        begin
            pin.valid = script[n].pinned;
            pin.beat.kind = script[n].exp_kind;
            pin.beat.count = script[n].exp_count;
            pin.beat.sync = script[n].sync;
            send_event(script[n].kind, script[n].value, script[n].sync, pin);
        end
        wait_drained();

        touching = 1'b1;
        pos_x = 2047;
        pos_y = 1032;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure(12'd0, 12'd1, 1'b1, 1'b0);
                1: configure(12'd4095, 12'd4095, 1'b0, 1'b1);
                2: configure(12'd1, 12'd0, 1'b0, 1'b1);
                3: configure(12'($urandom_range(1, 64)), 12'($urandom_range(1, 64)),
                             1'b1, 1'b1);
                5: configure(12'd3, 12'd7, 1'b1, 1'b0);
                default: configure(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            no_idle = (phase == 4);

            // Full-panel swipes at unit pitch give the largest counts of both signs.
            if (phase == 2)
            begin
                send_plain(EV_TOUCH, 12'd0, 1'b0);
                send_plain(EV_TOUCH, 12'd1, 1'b0);
                send_plain(EV_ABS_X, 12'd0, 1'b0);
                send_plain(EV_ABS_X, 12'hFFF, 1'b1);
                send_plain(EV_ABS_X, 12'd0, 1'b0);
                send_plain(EV_ABS_Y, 12'hFFF, 1'b0);
                send_plain(EV_ABS_Y, 12'd0, 1'b1);
                pos_x = 0;
                pos_y = 0;
                touching = 1'b1;
            end

            for (n = 0; n < PHASE_EVENTS; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    no_idle = ~no_idle;
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
                roll = int'($urandom_range(0, 99));
                sync = ($urandom_range(0, 3) == 0);
                if (roll < 12)
                begin
                    kind = event_kind_t'($urandom_range(0, 3));
                    value = 12'($urandom_range(0, 4095));
                    if (kind == EV_TOUCH)
                        touching = (value != 12'd0);
                end
                else if (!touching)
                begin
                    kind = EV_TOUCH;
                    value = 12'($urandom_range(1, 4095));
                    touching = 1'b1;
                end
                else if (roll < 16)
                begin
                    kind = EV_TOUCH;
                    value = 12'd0;
                    touching = 1'b0;
                end
                else if (roll < 19)
                begin
                    kind = EV_OTHER;
                    value = 12'($urandom_range(0, 4095));
                end
                else if (roll < 21)
                begin
                    kind = EV_TOUCH;
                    value = 12'($urandom_range(1, 4095));
                end
                else if (roll < 60)
                begin
                    kind = EV_ABS_X;
                    pos_x = walk_coord(pos_x);
                    value = 12'(pos_x);
                end
                else
                begin
                    kind = EV_ABS_Y;
                    pos_y = walk_coord(pos_y);
                    value = 12'(pos_y);
                end
                send_plain(kind, value, sync);
            end
            wait_drained();
        end

        no_idle = 1'b0;
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && wheel_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/tdws_pkg.sv
src/tdws_ctrl.sv
src/tdws_dp.sv
src/touch_drag_to_wheel_scroll_core.sv
src/tdws_checker.sv
test/touch_drag_to_wheel_scroll_core_tb.sv
